// ----- rtl/first_fit_block_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// first fit allocator assertion macros
// shared property forms for the allocator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFBA_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// status codes and memory control type of the first fit allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

   typedef logic [1:0] ffba_status_type;

   localparam ffba_status_type ST_OK        = 2'd0;
   localparam ffba_status_type ST_BAD_SIZE  = 2'd1;
   localparam ffba_status_type ST_NO_SPACE  = 2'd2;
   localparam ffba_status_type ST_NOT_FOUND = 2'd3;

   // write controls toward the block store
   typedef struct packed {
      logic map_we;
      logic map_wdata;
      logic rl_we;
   } ffba_mem_ctl_type;

endpackage

// ----- rtl/ffba_req_if.sv -----
// ----------------------------------------------------------------------------
// ffba_req_if
// request channel: allocate size or free offset, valid/ready handshake
// ----------------------------------------------------------------------------
interface ffba_req_if #(
   parameter int PAGE_BYTES = 4096
) ();
   localparam int SIZE_W = $clog2(PAGE_BYTES + 1);
   localparam int OFF_W  = $clog2(PAGE_BYTES);

   logic              valid;
   logic              ready;
   logic              func;
   logic [SIZE_W-1:0] size_bytes;
   logic [OFF_W-1:0]  free_offset;

   modport source (output valid, output func, output size_bytes, output free_offset,
                   input ready);
   modport sink   (input valid, input func, input size_bytes, input free_offset,
                   output ready);
endinterface

// ----- rtl/ffba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ffba_rsp_if
// response channel: status and byte offset, valid/ready handshake
// ----------------------------------------------------------------------------
interface ffba_rsp_if #(
   parameter int PAGE_BYTES = 4096
) ();
   localparam int OFF_W = $clog2(PAGE_BYTES);

   logic                      valid;
   logic                      ready;
   ffba_pkg::ffba_status_type status;
   logic [OFF_W-1:0]          offset;

   modport source (output valid, output status, output offset, input ready);
   modport sink   (input valid, input status, input offset, output ready);
endinterface

// ----- rtl/ffba_alu.sv -----
// ----------------------------------------------------------------------------
// ffba_alu
// shared add and compare unit reused by the decode, scan and mark phases
// ----------------------------------------------------------------------------
module ffba_alu #(
   parameter int W = 13
) (
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   input  logic [W-1:0] cmp,
   output logic [W-1:0] sum,
   output logic         eq,
   output logic         gt
);
   assign sum = opa + opb;
   assign eq  = (opa == cmp);
   assign gt  = (opa > cmp);
endmodule

// ----- rtl/ffba_store.sv -----
// ----------------------------------------------------------------------------
// ffba_store
// block used map and run length record, one write port each, registered read
// ----------------------------------------------------------------------------
module ffba_store #(
   parameter int DEPTH = 512,
   parameter int RL_W  = 10
) (
   input  logic                       clock,
   input  ffba_pkg::ffba_mem_ctl_type ctl,
   input  logic [$clog2(DEPTH)-1:0]   map_waddr,
   input  logic [$clog2(DEPTH)-1:0]   rl_waddr,
   input  logic [RL_W-1:0]            rl_wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic                       map_q,
   output logic [RL_W-1:0]            rl_q
);
   logic            map_ram_ff [DEPTH];
   logic [RL_W-1:0] rl_ram_ff  [DEPTH];
   logic            map_q_ff;
   logic [RL_W-1:0] rl_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.map_we) begin
         map_ram_ff[map_waddr] <= ctl.map_wdata;
      end
      if (ctl.rl_we) begin
         rl_ram_ff[rl_waddr] <= rl_wdata;
      end
      map_q_ff <= map_ram_ff[raddr];
      rl_q_ff  <= rl_ram_ff[raddr];
   end

   assign map_q = map_q_ff;
   assign rl_q  = rl_q_ff;
endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first fit run allocator over one page of fixed size blocks
// ----------------------------------------------------------------------------
//
// channel   dir  word
// req_if    in   func, size_bytes, free_offset
// rsp_if    out  status, offset
//
// after reset a clearing pass writes every block entry, with req_if.ready
// low throughout
// allocate: a decode state checks the size (mask for alignment, shared
// compare for oversize, shift for the block count), then the first fit scan
// reads one map entry a cycle and marking sets each block of the run in turn
// free: a decode state, a record read, then marking clears each block of the run
// one word in flight; the result register lets rsp_if stall while the next
// word is already accepted, a full result register holds the sequencer
// block size is a power of two
//
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator #(
   parameter int PAGE_BYTES  = 4096,
   parameter int BLOCK_BYTES = 8
) (
   input  logic         clock,
   input  logic         reset,
   ffba_req_if.sink     req_if,
   ffba_rsp_if.source   rsp_if
);
   localparam int BLOCKS   = PAGE_BYTES / BLOCK_BYTES;
   localparam int SIZE_W   = $clog2(PAGE_BYTES + 1);
   localparam int OFF_W    = $clog2(PAGE_BYTES);
   localparam int CNT_W    = $clog2(BLOCKS + 1);
   localparam int IDX_W    = $clog2(BLOCKS);
   localparam int BB_SHIFT = $clog2(BLOCK_BYTES);

   localparam logic [CNT_W-1:0]  CNT_BLOCKS = CNT_W'(BLOCKS);
   localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);
   localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(BLOCKS - 1);
   localparam logic [IDX_W-1:0]  IDX_ONE    = IDX_W'(1);
   localparam logic [SIZE_W-1:0] STEP_ONE   = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] PAGE_LIM   = SIZE_W'(PAGE_BYTES);
   localparam logic [SIZE_W-1:0] OFF_LIM    = SIZE_W'(PAGE_BYTES - BLOCK_BYTES);

   // sequencer states
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_LOCATE  = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd3;
   localparam logic [2:0] S_SCAN    = 3'd4;
   localparam logic [2:0] S_MARK    = 3'd5;
   localparam logic [2:0] S_RESP    = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic                      func_ff, func_in;
   logic [SIZE_W-1:0]         target_ff, target_in;      // size or offset in bytes
   logic [CNT_W-1:0]          scan_ff, scan_in;          // block counter, read address
   logic                      chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;            // free run length / mark count
   logic [CNT_W-1:0]          n_ff, n_in;                // run length in blocks
   logic [CNT_W-1:0]          start_ff, start_in;        // candidate run start
   logic [IDX_W-1:0]          mark_addr_ff, mark_addr_in;
   logic                      mark_val_ff, mark_val_in;
   ffba_pkg::ffba_status_type res_status_ff, res_status_in;
   logic [OFF_W-1:0]          res_offset_ff, res_offset_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ffba_pkg::ffba_status_type rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]          rsp_offset_ff, rsp_offset_in;

   logic                       rsp_load;
   logic [SIZE_W-1:0]          alu_opa, alu_opb, alu_cmp, alu_sum;
   logic                       alu_eq, alu_gt;
   ffba_pkg::ffba_mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]           rl_waddr;
   logic [CNT_W-1:0]           rl_wdata;
   logic                       map_q;
   logic [CNT_W-1:0]           rl_q;
   logic                       scan_last;
   logic                       unaligned;
   logic                       size_bad;
   logic [CNT_W-1:0]           size_blocks;

   // shared add and compare
   ffba_alu #(
      .W (SIZE_W)
   ) u_alu (
      .opa (alu_opa),
      .opb (alu_opb),
      .cmp (alu_cmp),
      .sum (alu_sum),
      .eq  (alu_eq),
      .gt  (alu_gt)
   );

   ffba_store #(
      .DEPTH (BLOCKS),
      .RL_W  (CNT_W)
   ) u_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .map_waddr (mark_addr_ff),
      .rl_waddr  (rl_waddr),
      .rl_wdata  (rl_wdata),
      .raddr     (scan_ff[IDX_W-1:0]),
      .map_q     (map_q),
      .rl_q      (rl_q)
   );

   // decode compares the word against the page limit or last block offset, scan and mark count blocks
   always_comb begin
      if (state_ff == S_LOCATE) begin
         alu_opa = target_ff;
         alu_opb = STEP_ONE;
         alu_cmp = func_ff ? OFF_LIM : PAGE_LIM;
      end else begin
         alu_opa = SIZE_W'(cnt_ff);
         alu_opb = STEP_ONE;
         alu_cmp = SIZE_W'(n_ff);
      end
   end

   // low bits below the block size must be clear
   assign unaligned   = (target_ff[BB_SHIFT-1:0] != '0);
   assign size_bad    = (target_ff == '0) || unaligned || alu_gt;
   assign size_blocks = CNT_W'(target_ff >> BB_SHIFT);

   // the check in flight is for the last block once the reader has run out
   assign scan_last = (scan_ff == CNT_BLOCKS);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      target_in     = target_ff;
      scan_in       = scan_ff;
      chk_valid_in  = chk_valid_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      mark_addr_in  = mark_addr_ff;
      mark_val_in   = mark_val_ff;
      res_status_in = res_status_ff;
      res_offset_in = res_offset_ff;
      rsp_load      = 1'b0;
      mem_ctl       = '0;
      rl_waddr      = start_ff[IDX_W-1:0];
      rl_wdata      = n_ff;
      req_if.ready  = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // one entry of both stores per cycle
            mem_ctl.map_we = 1'b1;
            mem_ctl.rl_we  = 1'b1;
            rl_waddr       = mark_addr_ff;
            rl_wdata       = '0;
            mark_addr_in   = mark_addr_ff + IDX_ONE;
            if (mark_addr_ff == IDX_LAST) begin
               mark_addr_in = '0;
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               func_in   = req_if.func;
               target_in = req_if.func ? SIZE_W'(req_if.free_offset) : req_if.size_bytes;
               // a free reads its run record at the offset's block
               scan_in   = req_if.func ? CNT_W'(req_if.free_offset >> BB_SHIFT) : '0;
               state_in  = S_LOCATE;
            end
         end
         S_LOCATE: begin
            // decode of the word
            start_in = scan_ff;
            if (!func_ff) begin
               if (size_bad) begin
                  // zero, unaligned or above the page
                  res_status_in = ffba_pkg::ST_BAD_SIZE;
                  res_offset_in = '0;
                  state_in      = S_RESP;
               end else begin
                  n_in         = size_blocks;
                  scan_in      = '0;
                  cnt_in       = CNT_ONE;
                  start_in     = '0;
                  chk_valid_in = 1'b0;
                  state_in     = S_SCAN;
               end
            end else if (unaligned || alu_gt) begin
               // unaligned or beyond the last block
               res_status_in = ffba_pkg::ST_NOT_FOUND;
               res_offset_in = '0;
               state_in      = S_RESP;
            end else begin
               // run record read issued at this block this cycle
               state_in = S_FREE_RD;
            end
         end
         S_FREE_RD: begin
            if (rl_q == '0) begin
               res_status_in = ffba_pkg::ST_NOT_FOUND;
               res_offset_in = '0;
               state_in      = S_RESP;
            end else begin
               n_in          = rl_q;
               mem_ctl.rl_we = 1'b1;
               rl_wdata      = '0;
               mark_addr_in  = start_ff[IDX_W-1:0];
               cnt_in        = CNT_ONE;
               mark_val_in   = 1'b0;
               state_in      = S_MARK;
            end
         end
         S_SCAN: begin
            // reader runs one block ahead of the check
            if (!scan_last) begin
               scan_in = scan_ff + CNT_ONE;
            end
            chk_valid_in = !scan_last;
            if (chk_valid_ff) begin
               if (map_q) begin
                  cnt_in   = CNT_ONE;
                  start_in = scan_ff;
                  if (scan_last) begin
                     res_status_in = ffba_pkg::ST_NO_SPACE;
                     res_offset_in = '0;
                     state_in      = S_RESP;
                  end
               end else if (alu_eq) begin
                  // fit found, record the run length at its start
                  mem_ctl.rl_we = 1'b1;
                  mark_addr_in  = start_ff[IDX_W-1:0];
                  cnt_in        = CNT_ONE;
                  mark_val_in   = 1'b1;
                  state_in      = S_MARK;
               end else begin
                  cnt_in = CNT_W'(alu_sum);
                  if (scan_last) begin
                     res_status_in = ffba_pkg::ST_NO_SPACE;
                     res_offset_in = '0;
                     state_in      = S_RESP;
                  end
               end
            end
         end
         S_MARK: begin
            // set or clear one block of the run per cycle
            mem_ctl.map_we    = 1'b1;
            mem_ctl.map_wdata = mark_val_ff;
            if (alu_eq) begin
               res_status_in = ffba_pkg::ST_OK;
               res_offset_in = mark_val_ff ? OFF_W'(start_ff * BLOCK_BYTES) : '0;
               state_in      = S_RESP;
            end else begin
               cnt_in       = CNT_W'(alu_sum);
               mark_addr_in = mark_addr_ff + IDX_ONE;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_offset_in = res_offset_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mark_addr_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_addr_ff <= mark_addr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      target_ff     <= target_in;
      scan_ff       <= scan_in;
      cnt_ff        <= cnt_in;
      n_ff          <= n_in;
      start_ff      <= start_in;
      mark_val_ff   <= mark_val_in;
      res_status_ff <= res_status_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.offset = rsp_offset_ff;

   // scan always has a nonzero run length inside the page
   `FFBA_HOLDS(a_scan_len, clock, reset, state_ff == S_SCAN, (n_ff != '0) && (n_ff <= CNT_BLOCKS), "scan run length out of range")
   // mark count stays within the run
   `FFBA_HOLDS(a_mark_cnt, clock, reset, state_ff == S_MARK, (cnt_ff != '0) && (cnt_ff <= n_ff), "mark count beyond run")
   // block counter never passes the page end
   `FFBA_HOLDS(a_scan_bound, clock, reset, (state_ff == S_LOCATE) || (state_ff == S_SCAN), scan_ff <= CNT_BLOCKS, "block counter beyond page")
   // an accepted word starts the decode
   `FFBA_NEXT(a_accept, clock, reset, req_if.valid && req_if.ready, state_ff == S_LOCATE, "accept did not start locate")
   // a finished word lands in the result register
   `FFBA_NEXT(a_load, clock, reset, (state_ff == S_RESP) && (!rsp_valid_ff || rsp_if.ready), rsp_valid_ff && (state_ff == S_IDLE), "result not loaded")

endmodule
